### rtl/wnms_pkg.sv
package wnms_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int WINDOW     = 3;

    localparam int POS_W      = 6;
    localparam int SIZE_W     = 7;
    localparam int VAL_W      = 16;
    localparam int SUM_W      = 20;
    localparam int WROW_W     = WINDOW * VAL_W;
    localparam int WRAP_W     = 4;

    localparam int RIDX_W     = $clog2(MAX_ROWS);
    localparam int CIDX_W     = $clog2(MAX_COLS);
    localparam int ADDR_W     = $clog2(MAX_ROWS * MAX_COLS);
    localparam int WIN_W      = $clog2(WINDOW);
    localparam int BIT_W      = $clog2(POS_W);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam int WRAP_COL_HI = 0;
    localparam int WRAP_ROW_HI = 1;
    localparam int WRAP_COL_LO = 2;
    localparam int WRAP_ROW_LO = 3;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_ROWS       = 3'd0,
        REG_GRID_COLS       = 3'd1,
        REG_MATCH_VALUE     = 3'd2,
        REG_MATCH_TOLERANCE = 3'd3,
        REG_WRAP_SIDES      = 3'd4,
        REG_WEIGHTS_LEFT    = 3'd5,
        REG_WEIGHTS_CENTRE  = 3'd6,
        REG_WEIGHTS_RIGHT   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        op_t              op;
        logic             reduce;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [SIZE_W-1:0]                        rows_n;
        logic [SIZE_W-1:0]                        cols_n;
        logic [VAL_W-1:0]                         match_value;
        logic [VAL_W-1:0]                         tolerance;
        logic [WRAP_W-1:0]                        wrap;
        logic [WINDOW-1:0][WINDOW-1:0][VAL_W-1:0] weights;
    } cfg_t;

    function automatic logic [SIZE_W-1:0] limit_size(input logic [SIZE_W-1:0] v,
                                                     input int maxv);
        logic [SIZE_W-1:0] res;
        res = v;
        if (v == '0)
            res = SIZE_W'(1);
        else if (int'(v) > maxv)
            res = SIZE_W'(maxv);
        return res;
    endfunction

endpackage

### rtl/wnms_front.sv
module wnms_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic [wnms_pkg::POS_W-1:0]    row,
    input  logic [wnms_pkg::POS_W-1:0]    col,
    input  logic [wnms_pkg::VAL_W-1:0]    cell_value,
    input  logic [wnms_pkg::SIZE_W-1:0]   rows_n,
    input  logic [wnms_pkg::SIZE_W-1:0]   cols_n,
    output logic                          push_valid,
    input  logic                          push_ready,
    output wnms_pkg::cmd_t                push_cmd
);
    import wnms_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    cmd_t hold_cmd_reg;
    cmd_t hold_cmd_next;
    cmd_t in_cmd;
    logic in_fire;

    assign in_ready   = !hold_valid_reg || push_ready;
    assign in_fire    = in_valid && in_ready;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = hold_cmd_reg;

    // classify: evaluates outside the grid in use need a coordinate reduction
    always_comb
    begin
        in_cmd.op     = op_t'(operation);
        in_cmd.row    = row;
        in_cmd.col    = col;
        in_cmd.value  = cell_value;
        in_cmd.reduce = (in_cmd.op == OP_EVAL) &&
                        ((SIZE_W'(row) >= rows_n) || (SIZE_W'(col) >= cols_n));
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_cmd_next   = hold_cmd_reg;
        if (push_valid && push_ready)
            hold_valid_next = 1'b0;
        if (in_fire)
        begin
            hold_valid_next = 1'b1;
            hold_cmd_next   = in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule

### rtl/wnms_queue.sv
module wnms_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  wnms_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output wnms_pkg::cmd_t pop_cmd
);
    import wnms_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              push_fire;
    logic              pop_fire;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop_fire)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push_fire && !pop_fire)
            count_next = count_reg + 1'b1;
        else if (pop_fire && !push_fire)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

### rtl/wnms_back.sv
module wnms_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wnms_pkg::cfg_t              cfg,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  wnms_pkg::cmd_t              pop_cmd,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [wnms_pkg::SUM_W-1:0]  out_sum
);
    import wnms_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MOD    = 6'b000010,
        ST_SETUP  = 6'b000100,
        ST_READ   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    typedef struct packed {
        logic [WINDOW-1:0]             valid;
        logic [WINDOW-1:0][SIZE_W-1:0] idx;
    } axis_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [POS_W-1:0]              row_reg;
    logic [POS_W-1:0]              row_next;
    logic [POS_W-1:0]              col_reg;
    logic [POS_W-1:0]              col_next;
    logic [SIZE_W-1:0]             rrem_reg;
    logic [SIZE_W-1:0]             rrem_next;
    logic [SIZE_W-1:0]             crem_reg;
    logic [SIZE_W-1:0]             crem_next;
    logic [BIT_W-1:0]              bit_reg;
    logic [BIT_W-1:0]              bit_next;
    logic [WINDOW-1:0]             rv_reg;
    logic [WINDOW-1:0]             rv_next;
    logic [WINDOW-1:0]             cv_reg;
    logic [WINDOW-1:0]             cv_next;
    logic [WINDOW-1:0][RIDX_W-1:0] ridx_reg;
    logic [WINDOW-1:0][RIDX_W-1:0] ridx_next;
    logic [WINDOW-1:0][CIDX_W-1:0] cidx_reg;
    logic [WINDOW-1:0][CIDX_W-1:0] cidx_next;
    logic [WIN_W-1:0]              dr_reg;
    logic [WIN_W-1:0]              dr_next;
    logic [WIN_W-1:0]              dc_reg;
    logic [WIN_W-1:0]              dc_next;
    logic signed [SUM_W-1:0]       acc_reg;
    logic signed [SUM_W-1:0]       acc_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [SUM_W-1:0]              out_sum_reg;
    logic [SUM_W-1:0]              out_sum_next;

    logic                          rd_v_reg;
    logic                          rd_last_reg;
    logic                          rd_in_reg;
    logic [VAL_W-1:0]              rd_w_reg;
    logic [VAL_W-1:0]              rd_data_reg;
    logic                          m_v_reg;
    logic                          m_last_reg;
    logic                          m_hit_reg;
    logic [VAL_W-1:0]              m_w_reg;

    logic [VAL_W-1:0]              grid_mem_reg [MAX_ROWS * MAX_COLS];
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_addr;
    logic [ADDR_W-1:0]             wr_addr;
    logic [ADDR_W-1:0]             rd_addr;

    logic                          pop_fire;
    logic                          issue;
    logic                          last_step;
    logic                          slot_free;
    logic [SIZE_W-1:0]             rshift;
    logic [SIZE_W-1:0]             cshift;
    axis_t                         raxis;
    axis_t                         caxis;
    logic [VAL_W-1:0]              win_val;
    logic signed [VAL_W:0]         diff;
    logic [VAL_W:0]                adiff;
    logic                          hit;

    function automatic axis_t resolve_axis(input logic [POS_W-1:0]  pos,
                                           input logic [SIZE_W-1:0] rem,
                                           input logic [SIZE_W-1:0] n,
                                           input logic              wrap_hi,
                                           input logic              wrap_lo);
        axis_t             a;
        logic              lo;
        logic              hi;
        logic [SIZE_W-1:0] ext;
        for (int d = 0; d < WINDOW; d++)
        begin
            ext = SIZE_W'(pos) + SIZE_W'(d);
            lo  = (d == 0) && (pos == '0);
            hi  = !lo && (ext > n);
            a.valid[d] = lo ? wrap_lo : (hi ? wrap_hi : 1'b1);
            if (d == 0)
                a.idx[d] = (rem == '0) ? n - 1'b1 : rem - 1'b1;
            else if (d == 1)
                a.idx[d] = rem;
            else
                a.idx[d] = (rem + 1'b1 == n) ? '0 : rem + 1'b1;
        end
        return a;
    endfunction

    assign pop_ready = state_reg == ST_IDLE;
    assign pop_fire  = pop_valid && pop_ready;
    assign issue     = state_reg == ST_READ;
    assign last_step = (dr_reg == WIN_W'(WINDOW - 1)) && (dc_reg == WIN_W'(WINDOW - 1));
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_sum   = out_sum_reg;

    assign mem_we   = pop_fire && (pop_cmd.op == OP_WRITE);
    assign wr_addr  = ADDR_W'(pop_cmd.row) * ADDR_W'(MAX_COLS) + ADDR_W'(pop_cmd.col);
    assign rd_addr  = ADDR_W'(ridx_reg[dr_reg]) * ADDR_W'(MAX_COLS)
                    + ADDR_W'(cidx_reg[dc_reg]);
    assign mem_addr = issue ? rd_addr : wr_addr;

    // one restoring step per cycle on both coordinates
    assign rshift = {rrem_reg[SIZE_W-2:0], row_reg[bit_reg]};
    assign cshift = {crem_reg[SIZE_W-2:0], col_reg[bit_reg]};

    assign raxis = resolve_axis(row_reg, rrem_reg, cfg.rows_n,
                                cfg.wrap[WRAP_ROW_HI], cfg.wrap[WRAP_ROW_LO]);
    assign caxis = resolve_axis(col_reg, crem_reg, cfg.cols_n,
                                cfg.wrap[WRAP_COL_HI], cfg.wrap[WRAP_COL_LO]);

    assign win_val = rd_in_reg ? rd_data_reg : '0;
    assign diff    = $signed({win_val[VAL_W-1], win_val})
                   - $signed({cfg.match_value[VAL_W-1], cfg.match_value});
    assign adiff   = diff[VAL_W] ? $unsigned(-diff) : $unsigned(diff);
    assign hit     = adiff < {1'b0, cfg.tolerance};

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        rrem_next      = rrem_reg;
        crem_next      = crem_reg;
        bit_next       = bit_reg;
        rv_next        = rv_reg;
        cv_next        = cv_reg;
        ridx_next      = ridx_reg;
        cidx_next      = cidx_reg;
        dr_next        = dr_reg;
        dc_next        = dc_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_sum_next   = out_sum_reg;

        if (out_ready)
            out_valid_next = 1'b0;

        if (m_v_reg && m_hit_reg)
            acc_next = acc_reg + SUM_W'($signed(m_w_reg));

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_fire && (pop_cmd.op == OP_EVAL))
                begin
                    row_next  = pop_cmd.row;
                    col_next  = pop_cmd.col;
                    bit_next  = BIT_W'(POS_W - 1);
                    rrem_next = pop_cmd.reduce ? '0 : SIZE_W'(pop_cmd.row);
                    crem_next = pop_cmd.reduce ? '0 : SIZE_W'(pop_cmd.col);
                    state_next = pop_cmd.reduce ? ST_MOD : ST_SETUP;
                end
            end
            ST_MOD:
            begin
                rrem_next = (rshift >= cfg.rows_n) ? rshift - cfg.rows_n : rshift;
                crem_next = (cshift >= cfg.cols_n) ? cshift - cfg.cols_n : cshift;
                bit_next  = bit_reg - 1'b1;
                if (bit_reg == '0)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                rv_next = raxis.valid;
                cv_next = caxis.valid;
                for (int d = 0; d < WINDOW; d++)
                begin
                    ridx_next[d] = RIDX_W'(raxis.idx[d]);
                    cidx_next[d] = CIDX_W'(caxis.idx[d]);
                end
                dr_next    = '0;
                dc_next    = '0;
                acc_next   = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (last_step)
                begin
                    dr_next    = '0;
                    dc_next    = '0;
                    state_next = ST_DRAIN;
                end
                else if (dr_reg == WIN_W'(WINDOW - 1))
                begin
                    dr_next = '0;
                    dc_next = dc_reg + 1'b1;
                end
                else
                    dr_next = dr_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (m_last_reg)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_sum_next   = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rd_v_reg      <= 1'b0;
            rd_last_reg   <= 1'b0;
            m_v_reg       <= 1'b0;
            m_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_v_reg      <= issue;
            rd_last_reg   <= issue && last_step;
            m_v_reg       <= rd_v_reg;
            m_last_reg    <= rd_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        col_reg     <= col_next;
        rrem_reg    <= rrem_next;
        crem_reg    <= crem_next;
        bit_reg     <= bit_next;
        rv_reg      <= rv_next;
        cv_reg      <= cv_next;
        ridx_reg    <= ridx_next;
        cidx_reg    <= cidx_next;
        dr_reg      <= dr_next;
        dc_reg      <= dc_next;
        acc_reg     <= acc_next;
        out_sum_reg <= out_sum_next;
        rd_in_reg   <= rv_reg[dr_reg] && cv_reg[dc_reg];
        rd_w_reg    <= cfg.weights[dc_reg][dr_reg];
        m_hit_reg   <= hit;
        m_w_reg     <= rd_w_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem_reg[mem_addr] <= pop_cmd.value;
        rd_data_reg <= grid_mem_reg[mem_addr];
    end

`ifndef ASSERT_OFF
    a_drain_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
        m_last_reg |=> state_reg == ST_FINISH)
        else $error("last window cell did not lead to result");

    a_setup_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SETUP) |-> (!rd_v_reg && !m_v_reg))
        else $error("accumulator cleared with reads in flight");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !out_ready)
            |=> state_reg == ST_FINISH)
        else $error("result overwrote a waiting result");
`endif

endmodule

### rtl/weighted_neighbourhood_match_sum.sv
// Weighted 3x3 neighbourhood match sum over a 64x64 grid of 16-bit signed cells.
// A write request (operation 0) stores cell_value at (row, col) and yields no
// result; an evaluate request (operation 1) yields one neighbour_sum, the Q12.8
// sum of the weights of the window cells whose value differs from match_value
// by less than match_tolerance. Window cells off the grid in use read as 0
// unless the wrap bit of that side is set. Configuration is to be written
// through cfg_write/cfg_index/cfg_data only while no request is outstanding; the
// block does not enforce this. The grid sits in a single-port memory that is not
// cleared; a cell must be written before any window reads it. The back end takes
// a write in its idle state; an evaluate runs setup, nine window reads at one
// per cycle from the grid memory port, a two-stage compare/accumulate pipeline
// and the result load. An evaluate whose row is at or beyond grid_rows, or whose
// column is at or beyond grid_cols, first goes through a bit-serial coordinate
// reduction. A two-entry queue and an input register let up to three further
// requests be accepted while an evaluate is in progress, and a finished result
// waits in an output register without blocking new requests.
module weighted_neighbourhood_match_sum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [wnms_pkg::POS_W-1:0]          row,
    input  logic [wnms_pkg::POS_W-1:0]          col,
    input  logic signed [wnms_pkg::VAL_W-1:0]   cell_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [wnms_pkg::SUM_W-1:0]   neighbour_sum,
    input  logic                                cfg_write,
    input  logic [wnms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wnms_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wnms_pkg::*;

    logic [SIZE_W-1:0] grid_rows_reg;
    logic [SIZE_W-1:0] grid_cols_reg;
    logic [VAL_W-1:0]  match_value_reg;
    logic [VAL_W-1:0]  match_tolerance_reg;
    logic [WRAP_W-1:0] wrap_sides_reg;
    logic [WROW_W-1:0] weights_left_reg;
    logic [WROW_W-1:0] weights_centre_reg;
    logic [WROW_W-1:0] weights_right_reg;

    cfg_t              cfg;
    logic              push_valid;
    logic              push_ready;
    cmd_t              push_cmd;
    logic              pop_valid;
    logic              pop_ready;
    cmd_t              pop_cmd;
    logic [SUM_W-1:0]  sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg       <= SIZE_W'(MAX_ROWS);
            grid_cols_reg       <= SIZE_W'(MAX_COLS);
            match_value_reg     <= '0;
            match_tolerance_reg <= VAL_W'(1);
            wrap_sides_reg      <= '0;
            weights_left_reg    <= '0;
            weights_centre_reg  <= '0;
            weights_right_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_GRID_ROWS:       grid_rows_reg       <= cfg_data[SIZE_W-1:0];
                REG_GRID_COLS:       grid_cols_reg       <= cfg_data[SIZE_W-1:0];
                REG_MATCH_VALUE:     match_value_reg     <= cfg_data[VAL_W-1:0];
                REG_MATCH_TOLERANCE: match_tolerance_reg <= cfg_data[VAL_W-1:0];
                REG_WRAP_SIDES:      wrap_sides_reg      <= cfg_data[WRAP_W-1:0];
                REG_WEIGHTS_LEFT:    weights_left_reg    <= cfg_data[WROW_W-1:0];
                REG_WEIGHTS_CENTRE:  weights_centre_reg  <= cfg_data[WROW_W-1:0];
                REG_WEIGHTS_RIGHT:   weights_right_reg   <= cfg_data[WROW_W-1:0];
                default:             grid_rows_reg       <= grid_rows_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.rows_n      = limit_size(grid_rows_reg, MAX_ROWS);
        cfg.cols_n      = limit_size(grid_cols_reg, MAX_COLS);
        cfg.match_value = match_value_reg;
        cfg.tolerance   = match_tolerance_reg;
        cfg.wrap        = wrap_sides_reg;
        cfg.weights[0]  = weights_left_reg;
        cfg.weights[1]  = weights_centre_reg;
        cfg.weights[2]  = weights_right_reg;
    end

    wnms_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .row        (row),
        .col        (col),
        .cell_value (cell_value),
        .rows_n     (cfg.rows_n),
        .cols_n     (cfg.cols_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    wnms_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    wnms_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_sum   (sum)
    );

    assign neighbour_sum = $signed(sum);

endmodule
